@@ rtl/core/chha_pkg.sv @@
// chha_pkg: types and codes shared by the calorimeter cell hit accumulator
// no dependencies

package chha_pkg;

	localparam logic [1:0] OP_DEPOSIT = 2'd0;
	localparam logic [1:0] OP_CLEAR   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	typedef enum logic [2:0] {
		ST_MERGED  = 3'd0,
		ST_NEW     = 3'd1,
		ST_ZERO    = 3'd2,
		ST_FULL    = 3'd3,
		ST_READ    = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef struct packed {
		logic [47:0] pos;
		logic [31:0] total;
		logic [31:0] em;
		logic [31:0] had;
		logic [31:0] first_time;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  entry_index;
		logic [6:0]  entry_count;
		entry_t      entry;
	} res_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

@@ rtl/core/chha_in_if.sv @@
// chha_in_if: input channel of the hit accumulator, valid/ready plus item fields
// no dependencies

interface chha_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [15:0] cell_x;
	logic signed [15:0] cell_y;
	logic signed [15:0] cell_z;
	logic [23:0]        deposit_kev;
	logic [31:0]        step_time_ns;
	logic               is_em;
	logic [5:0]         read_index;

	modport source(output valid, op, cell_x, cell_y, cell_z, deposit_kev, step_time_ns,
		is_em, read_index, input ready);
	modport sink(input valid, op, cell_x, cell_y, cell_z, deposit_kev, step_time_ns,
		is_em, read_index, output ready);
endinterface

@@ rtl/core/chha_out_if.sv @@
// chha_out_if: result channel of the hit accumulator, valid/ready plus item fields
// no dependencies

interface chha_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [5:0]         entry_index;
	logic [6:0]         entry_count;
	logic signed [15:0] hit_x;
	logic signed [15:0] hit_y;
	logic signed [15:0] hit_z;
	logic [31:0]        total_kev;
	logic [31:0]        em_kev;
	logic [31:0]        hadronic_kev;
	logic [31:0]        first_time_ns;

	modport source(output valid, status, entry_index, entry_count, hit_x, hit_y, hit_z,
		total_kev, em_kev, hadronic_kev, first_time_ns, input ready);
	modport sink(input valid, status, entry_index, entry_count, hit_x, hit_y, hit_z,
		total_kev, em_kev, hadronic_kev, first_time_ns, output ready);
endinterface

@@ rtl/core/calorimeter_cell_hit_accumulator.sv @@
// calorimeter_cell_hit_accumulator: per-event hit table held in one synchronous memory
// depends on chha_pkg, chha_in_if, chha_out_if
//
//  channel  dir  handshake      contents
//  in_ch    in   valid/ready    op, cell_x/y/z, deposit_kev, step_time_ns, is_em, read_index
//  out_ch   out  valid/ready    status, entry_index, entry_count, hit fields
//
// one item at a time; a deposit scans the table through the single read port, one entry
// per cycle, until it finds the cell or passes the valid entries; clear, zero deposit and
// read need no scan, a read of a valid entry waits in S_RDWAIT, an unused op gives no result
// the result sits in an output register so the next item is taken while it waits
// reset empties the table at once, entries are only read below the valid count
// a stalled output holds the block in its last step until the register frees

module calorimeter_cell_hit_accumulator
	import chha_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	chha_in_if.sink     in_ch,
	chha_out_if.source  out_ch
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MERGE,
		S_RDWAIT,
		S_FINISH
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   addr_q;
	logic            cmp_vld_s1;
	logic [AW-1:0]   cmp_idx_s1;
	entry_t          rdata_s1;
	entry_t          tbl_q [TABLE_DEPTH];
	logic [47:0]     pos_q;
	logic [23:0]     dep_q;
	logic [31:0]     time_q;
	logic            em_q;
	logic [5:0]      ridx_q;
	res_t            res_q;
	res_t            out_q;
	logic            out_valid_q;

	logic            hit;
	logic            issue_ok;
	logic            scan_miss;
	logic            full;
	logic            rd_ok_in;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	entry_t          merged;
	entry_t          fresh;

	function automatic res_t make_res(input status_t st, input logic [5:0] idx,
		input logic [6:0] cnt, input entry_t e);
		res_t r;
		r.status      = st;
		r.entry_index = idx;
		r.entry_count = cnt;
		r.entry       = e;
		return r;
	endfunction

	assign in_ch.ready = (state_q == S_IDLE);

	assign hit       = (state_q == S_SCAN) && cmp_vld_s1 && (rdata_s1.pos == pos_q);
	assign issue_ok  = (addr_q < count_q);
	assign scan_miss = (state_q == S_SCAN) && !hit && !issue_ok && !cmp_vld_s1;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign rd_ok_in  = ((CW + 6)'(in_ch.read_index) < (CW + 6)'(count_q));

	always_comb begin
		merged       = rdata_s1;
		merged.total = sat_add(rdata_s1.total, dep_q);
		if (em_q) begin
			merged.em = sat_add(rdata_s1.em, dep_q);
		end else begin
			merged.had = sat_add(rdata_s1.had, dep_q);
		end
		fresh.pos        = pos_q;
		fresh.total      = {8'd0, dep_q};
		fresh.em         = em_q ? {8'd0, dep_q} : 32'd0;
		fresh.had        = em_q ? 32'd0 : {8'd0, dep_q};
		fresh.first_time = time_q;
	end

	assign rd_en   = ((state_q == S_IDLE) && in_ch.valid && (in_ch.op == OP_READ) && rd_ok_in)
		|| ((state_q == S_SCAN) && issue_ok && !hit);
	assign rd_addr = (state_q == S_IDLE) ? AW'(in_ch.read_index) : addr_q[AW-1:0];
	assign wr_en   = (state_q == S_MERGE) || (scan_miss && !full);
	assign wr_addr = (state_q == S_MERGE) ? cmp_idx_s1 : count_q[AW-1:0];
	assign wr_data = (state_q == S_MERGE) ? merged : fresh;

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= tbl_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN) && !hit && issue_ok;
			if ((state_q == S_FINISH) && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						pos_q  <= {in_ch.cell_x, in_ch.cell_y, in_ch.cell_z};
						dep_q  <= in_ch.deposit_kev;
						time_q <= in_ch.step_time_ns;
						em_q   <= in_ch.is_em;
						ridx_q <= in_ch.read_index;
						unique case (in_ch.op)
							OP_CLEAR: begin
								count_q <= '0;
								res_q   <= make_res(ST_CLEARED, 6'd0, 7'd0, '0);
								state_q <= S_FINISH;
							end
							OP_READ: begin
								if (rd_ok_in) begin
									state_q <= S_RDWAIT;
								end else begin
									res_q   <= make_res(ST_READ, in_ch.read_index,
										7'(count_q), '0);
									state_q <= S_FINISH;
								end
							end
							OP_DEPOSIT: begin
								if (in_ch.deposit_kev == 24'd0) begin
									res_q   <= make_res(ST_ZERO, 6'd0, 7'(count_q), '0);
									state_q <= S_FINISH;
								end else begin
									addr_q  <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_MERGE;
					end else if (issue_ok) begin
						cmp_idx_s1 <= addr_q[AW-1:0];
						addr_q     <= addr_q + 1'b1;
					end else if (!cmp_vld_s1) begin
						if (full) begin
							res_q <= make_res(ST_FULL, 6'd0, 7'(count_q), '0);
						end else begin
							count_q <= count_q + 1'b1;
							res_q   <= make_res(ST_NEW, 6'(count_q),
								7'(count_q + 1'b1), fresh);
						end
						state_q <= S_FINISH;
					end
				end
				S_MERGE: begin
					res_q   <= make_res(ST_MERGED, 6'(cmp_idx_s1), 7'(count_q), merged);
					state_q <= S_FINISH;
				end
				S_RDWAIT: begin
					res_q   <= make_res(ST_READ, ridx_q, 7'(count_q), rdata_s1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_q.status;
	assign out_ch.entry_index   = out_q.entry_index;
	assign out_ch.entry_count   = out_q.entry_count;
	assign out_ch.hit_x         = out_q.entry.pos[47:32];
	assign out_ch.hit_y         = out_q.entry.pos[31:16];
	assign out_ch.hit_z         = out_q.entry.pos[15:0];
	assign out_ch.total_kev     = out_q.entry.total;
	assign out_ch.em_kev        = out_q.entry.em;
	assign out_ch.hadronic_kev  = out_q.entry.had;
	assign out_ch.first_time_ns = out_q.entry.first_time;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("valid count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1 || count_q == '0))
		else $error("valid count moved other than by append or clear");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_MERGE) ? (CW'(wr_addr) < count_q) : !full))
		else $error("table write outside the valid entries");

	a_merge_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> $past(hit))
		else $error("merge without a matching entry");
`endif

endmodule

@@ tb/hit_table_sb_pkg.sv @@
// hit_table_sb_pkg: item type and hit table scoreboard for the calorimeter hit accumulator bench
// depends on chha_pkg

package hit_table_sb_pkg;
	import chha_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [23:0]        kev;
		logic [31:0]        t;
		logic               em;
		logic [5:0]         ridx;
	} cell_item_t;

	class hit_table_tracker;
		entry_t      cells [TABLE_DEPTH];
		int unsigned n_valid;
		res_t        awaited [$];
		int          n_items;
		int          n_results;
		int          mismatches;
		int          status_seen [8];

		function logic [31:0] sat_sum(logic [31:0] acc, logic [23:0] add);
			if (acc > 32'hFFFF_FFFF - add) return 32'hFFFF_FFFF;
			return acc + add;
		endfunction

		function void note_item(cell_item_t it);
			res_t        r;
			logic [47:0] key;
			int          hit;
			r = '0;
			key = {it.x, it.y, it.z};
			hit = -1;
			n_items++;
			case (it.op)
			OP_CLEAR: begin
				n_valid = 0;
				r.status = ST_CLEARED;
			end
			OP_READ: begin
				r.status = ST_READ;
				r.entry_index = it.ridx;
				if (it.ridx < n_valid) r.entry = cells[it.ridx];
			end
			OP_DEPOSIT: begin
				if (it.kev == '0) begin
					r.status = ST_ZERO;
				end else begin
					for (int j = 0; j < n_valid; j++)
						if (hit < 0 && cells[j].pos == key) hit = j;
					if (hit >= 0) begin
						cells[hit].total = sat_sum(cells[hit].total, it.kev);
						if (it.em) cells[hit].em = sat_sum(cells[hit].em, it.kev);
						else cells[hit].had = sat_sum(cells[hit].had, it.kev);
						r.status = ST_MERGED;
						r.entry_index = 6'(hit);
						r.entry = cells[hit];
					end else if (n_valid >= TABLE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						cells[n_valid].pos = key;
						cells[n_valid].total = {8'd0, it.kev};
						cells[n_valid].em = it.em ? {8'd0, it.kev} : 32'd0;
						cells[n_valid].had = it.em ? 32'd0 : {8'd0, it.kev};
						cells[n_valid].first_time = it.t;
						r.status = ST_NEW;
						r.entry_index = 6'(n_valid);
						r.entry = cells[n_valid];
						n_valid++;
					end
				end
			end
			default: return;
			endcase
			r.entry_count = 7'(n_valid);
			awaited.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch at result %0d: %s", n_results, msg);
		endtask

		task compare(string field, logic [63:0] seen, logic [63:0] wanted);
			if (seen !== wanted)
				report($sformatf("%s got %0h, expected %0h", field, seen, wanted));
		endtask

		task check_result(res_t seen);
			res_t want;
			n_results++;
			if (awaited.size() == 0) begin
				report("result arrived with no item pending");
				return;
			end
			want = awaited.pop_front();
			status_seen[want.status]++;
			compare("status", seen.status, want.status);
			compare("entry_index", seen.entry_index, want.entry_index);
			compare("entry_count", seen.entry_count, want.entry_count);
			compare("hit_x", seen.entry.pos[47:32], want.entry.pos[47:32]);
			compare("hit_y", seen.entry.pos[31:16], want.entry.pos[31:16]);
			compare("hit_z", seen.entry.pos[15:0], want.entry.pos[15:0]);
			compare("total_kev", seen.entry.total, want.entry.total);
			compare("em_kev", seen.entry.em, want.entry.em);
			compare("hadronic_kev", seen.entry.had, want.entry.had);
			compare("first_time_ns", seen.entry.first_time, want.entry.first_time);
		endtask
	endclass

endpackage

@@ tb/tb_calorimeter_cell_hit_accumulator.sv @@
// tb_calorimeter_cell_hit_accumulator: directed and random deposits, reads and clears under
// varied pacing, results checked in order against the hit table scoreboard
// depends on chha_pkg, chha_in_if, chha_out_if, hit_table_sb_pkg, calorimeter_cell_hit_accumulator

module tb_calorimeter_cell_hit_accumulator;
	timeunit 1ns;
	timeprecision 1ps;
	import chha_pkg::*;
	import hit_table_sb_pkg::*;

	typedef enum {PACE_STEADY, PACE_SRC_SLOW, PACE_SINK_SLOW, PACE_BOTH_SLOW} pace_t;

	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic  clk;
	logic  arst_n;
	pace_t pace;
	bit    hold_req;
	logic  hold_off;
	int    quiet_cycles;

	hit_table_tracker tracker = new();

	chha_in_if  in_ch();
	chha_out_if out_ch();

	calorimeter_cell_hit_accumulator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int idle_pct(pace_t p, bit sink_side);
		case (p)
		PACE_SRC_SLOW:  return sink_side ? 0 : 83;
		PACE_SINK_SLOW: return sink_side ? 83 : 0;
		PACE_BOTH_SLOW: return 8;
		default:        return 0;
		endcase
	endfunction

	function automatic logic [47:0] rand_key();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic logic [23:0] rand_kev();
		case ($urandom_range(9))
		0:       return 24'd0;
		1:       return 24'hFF_FFFF;
		2:       return 24'($urandom_range(15, 1));
		default: return 24'($urandom);
		endcase
	endfunction

	function automatic cell_item_t deposit_at(logic [47:0] key, logic [23:0] kev,
		logic [31:0] t, logic em);
		cell_item_t it;
		it.op = OP_DEPOSIT;
		{it.x, it.y, it.z} = key;
		it.kev = kev;
		it.t = t;
		it.em = em;
		it.ridx = 6'($urandom);
		return it;
	endfunction

	function automatic cell_item_t control(logic [1:0] op, logic [5:0] idx);
		cell_item_t it;
		it = deposit_at(rand_key(), 24'($urandom), $urandom, 1'($urandom));
		it.op = op;
		it.ridx = idx;
		return it;
	endfunction

	function automatic logic [5:0] pick_index();
		if (tracker.n_valid > 0 && $urandom_range(1))
			return 6'($urandom_range(tracker.n_valid - 1));
		return 6'($urandom_range(63));
	endfunction

	task automatic send(cell_item_t it);
		while ($urandom_range(99) < idle_pct(pace, 1'b0)) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= it.op;
		in_ch.cell_x <= it.x;
		in_ch.cell_y <= it.y;
		in_ch.cell_z <= it.z;
		in_ch.deposit_kev <= it.kev;
		in_ch.step_time_ns <= it.t;
		in_ch.is_em <= it.em;
		in_ch.read_index <= it.ridx;
		do @(posedge clk); while (!in_ch.ready);
		tracker.note_item(it);
	endtask

	// one event: a pool of cell positions, many nearly alike, hit at random
	task automatic run_event(int n_items, int n_spots);
		logic [47:0] spots [$];
		logic [47:0] key;
		int          roll;
		spots.push_back(rand_key());
		while (spots.size() < n_spots) begin
			key = spots[$];
			case ($urandom_range(2))
			0:       key = rand_key();
			1:       key[15:0] = 16'($urandom);
			default: key[47:32] = 16'($urandom);
			endcase
			spots.push_back(key);
		end
		send(control(OP_CLEAR, '0));
		repeat (n_items) begin
			roll = $urandom_range(99);
			if (roll < 72)
				send(deposit_at(spots[$urandom_range(spots.size() - 1)], rand_kev(),
					$urandom, 1'($urandom)));
			else if (roll < 86)
				send(control(OP_READ, pick_index()));
			else if (roll < 92)
				send(deposit_at(rand_key(), rand_kev(), $urandom, 1'($urandom)));
			else if (roll < 96)
				send(control(OP_UNUSED, 6'($urandom)));
			else
				send(control(OP_CLEAR, '0));
		end
	endtask

	initial begin
		hold_off <= 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		res_t got;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.status = status_t'(out_ch.status);
				got.entry_index = out_ch.entry_index;
				got.entry_count = out_ch.entry_count;
				got.entry.pos = {out_ch.hit_x, out_ch.hit_y, out_ch.hit_z};
				got.entry.total = out_ch.total_kev;
				got.entry.em = out_ch.em_kev;
				got.entry.had = out_ch.hadronic_kev;
				got.entry.first_time = out_ch.first_time_ns;
				tracker.check_result(got);
			end
			out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct(pace, 1'b1));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, tracker.awaited.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [47:0] key;
		logic [47:0] filled [$];
		pace = PACE_STEADY;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_DEPOSIT;
		in_ch.cell_x <= '0;
		in_ch.cell_y <= '0;
		in_ch.cell_z <= '0;
		in_ch.deposit_kev <= '0;
		in_ch.step_time_ns <= '0;
		in_ch.is_em <= 1'b0;
		in_ch.read_index <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads of an empty table, unused op, zero energy, coordinate extremes
		send(control(OP_READ, 6'd0));
		send(control(OP_READ, 6'd63));
		send(control(OP_UNUSED, 6'd63));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0000}, 24'd0, 32'hFFFF_FFFF, 1'b1));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0000}, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0000}, 24'd1, 32'd0, 1'b0));
		send(deposit_at({16'h7FFF, 16'h8000, 16'hFFFF}, 24'd1, 32'd0, 1'b0));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0001}, 24'd5, 32'd7, 1'b0));
		send(deposit_at(48'd0, 24'hFF_FFFF, 32'h8000_0000, 1'b1));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0000}, 24'hFF_FFFF, 32'd3, 1'b1));
		send(deposit_at(48'd0, 24'd0, 32'd9, 1'b0));
		send(control(OP_READ, 6'd0));
		send(control(OP_READ, 6'd3));
		send(control(OP_READ, 6'd4));
		send(control(OP_READ, 6'd63));
		send(control(OP_CLEAR, 6'd0));
		send(control(OP_READ, 6'd0));
		send(deposit_at({16'h8000, 16'h7FFF, 16'h0000}, 24'd2, 32'd11, 1'b0));
		send(control(OP_READ, 6'd0));
		send(control(OP_CLEAR, 6'd63));

		// one cell hit until the total and em sums saturate
		pace = PACE_BOTH_SLOW;
		key = rand_key();
		send(control(OP_CLEAR, '0));
		repeat (262) send(deposit_at(key, 24'hFF_FFFF, $urandom, 1'b1));
		repeat (3) send(deposit_at(key, 24'hFF_FFFF, $urandom, 1'b0));
		send(control(OP_READ, '0));

		// fill the table with the output held off at first, then overflow, merge and read back
		pace = PACE_SINK_SLOW;
		send(control(OP_CLEAR, '0));
		hold_req = 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			key = rand_key();
			filled.push_back(key);
			send(deposit_at(key, 24'($urandom_range(16777215, 1)), $urandom, 1'(i)));
		end
		repeat (4) send(deposit_at(rand_key(), 24'($urandom_range(16777215, 1)),
			$urandom, 1'($urandom)));
		repeat (6) send(deposit_at(filled[$urandom_range(TABLE_DEPTH - 1)],
			rand_kev(), $urandom, 1'($urandom)));
		for (int i = 0; i < TABLE_DEPTH; i++) send(control(OP_READ, 6'(i)));

		for (int p = 0; p < 4; p++) begin
			pace = pace_t'(p);
			repeat (2) run_event(40, $urandom_range(20, 1));
			run_event(130, $urandom_range(160, 120));
		end

		in_ch.valid <= 1'b0;
		pace = PACE_STEADY;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.awaited.size() != 0)
			tracker.report($sformatf("%0d expected results never arrived",
				tracker.awaited.size()));

		$display("run: %0d items in, %0d results out; %0d merged, %0d new, %0d zero energy, %0d dropped on a full table",
			tracker.n_items, tracker.n_results, tracker.status_seen[ST_MERGED],
			tracker.status_seen[ST_NEW], tracker.status_seen[ST_ZERO],
			tracker.status_seen[ST_FULL]);
		$display("run: %0d reads, %0d clears, four pacing modes and a %0d-cycle output hold-off",
			tracker.status_seen[ST_READ], tracker.status_seen[ST_CLEARED], HOLD_CYCLES);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/chha_pkg.sv
rtl/core/chha_in_if.sv
rtl/core/chha_out_if.sv
rtl/core/calorimeter_cell_hit_accumulator.sv
tb/hit_table_sb_pkg.sv
tb/tb_calorimeter_cell_hit_accumulator.sv
